// ===== hdl/smavg_pkg.sv =====
package smavg_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 22;
   localparam int PTR_W       = 6;
   localparam int WIN_W       = 7;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = 5;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       end_of_stream;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ===== hdl/smavg_ctrl.sv =====
module smavg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  smavg_pkg::status_type status,
   output smavg_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/smavg_dpath.sv =====
module smavg_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [smavg_pkg::WIN_W-1:0]          csr_data,
   input  smavg_pkg::req_payload_type           req_payload,
   output smavg_pkg::rsp_payload_type           rsp_payload,
   input  smavg_pkg::cmd_type                   cmd,
   output smavg_pkg::status_type                status
);

   localparam int SW = smavg_pkg::SAMPLE_W;
   localparam int UW = smavg_pkg::SUM_W;
   localparam int PW = smavg_pkg::PTR_W;
   localparam int WW = smavg_pkg::WIN_W;
   localparam int TW = smavg_pkg::STEP_W;

   logic signed [SW-1:0] ring_mem [smavg_pkg::MAX_WINDOW];

   logic [WW-1:0]        window_ff;
   logic [WW-1:0]        win_eff;
   logic [PW-1:0]        old_addr;

   logic signed [SW-1:0] sample_ff;
   logic                 last_ff;
   logic signed [SW-1:0] old_ff;
   logic signed [UW-1:0] sum_ff;
   logic signed [UW-1:0] sum_in;
   logic [WW-1:0]        seen_ff;
   logic [PW-1:0]        wp_ff;
   logic                 drop_old;

   logic                 neg_ff;
   logic [UW-1:0]        quo_ff;
   logic [WW-1:0]        rem_ff;
   logic [WW:0]          rem_shift;
   logic [TW-1:0]        step_ff;

   logic [UW-1:0]              sum_mag;
   logic [SW-1:0]              avg;
   smavg_pkg::rsp_payload_type rsp_ff;

   always_comb begin
      if (window_ff == '0) begin
         win_eff = WW'(1);
      end else if (window_ff > WW'(smavg_pkg::MAX_WINDOW)) begin
         win_eff = WW'(smavg_pkg::MAX_WINDOW);
      end else begin
         win_eff = window_ff;
      end
   end

   assign old_addr = wp_ff - win_eff[PW-1:0];
   assign drop_old = (seen_ff >= win_eff);

   always_comb begin
      sum_in = sum_ff + UW'(sample_ff);
      if (drop_old) begin
         sum_in = sum_in - UW'(old_ff);
      end
   end

   assign sum_mag   = sum_in[UW-1] ? (UW'(0) - sum_in) : sum_in;
   assign rem_shift = {rem_ff, quo_ff[UW-1]};

   always_comb begin
      if (!neg_ff) begin
         avg = (quo_ff > UW'((1 << (SW - 1)) - 1)) ? {1'b0, {(SW-1){1'b1}}} : quo_ff[SW-1:0];
      end else begin
         avg = (quo_ff > UW'(1 << (SW - 1))) ? {1'b1, {(SW-1){1'b0}}}
                                             : (SW'(0) - quo_ff[SW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WW'(4);
         sum_ff    <= '0;
         seen_ff   <= '0;
         wp_ff     <= '0;
      end else begin
         if (csr_write) begin
            window_ff <= csr_data;
         end
         if (cmd.update) begin
            if (last_ff) begin
               sum_ff  <= '0;
               seen_ff <= '0;
               wp_ff   <= '0;
            end else begin
               sum_ff  <= sum_in;
               seen_ff <= drop_old ? seen_ff : (seen_ff + WW'(1));
               wp_ff   <= wp_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_payload.sample;
         last_ff   <= req_payload.last_sample;
         old_ff    <= ring_mem[old_addr];
      end
      if (cmd.update) begin
         ring_mem[wp_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         neg_ff  <= sum_in[UW-1];
         quo_ff  <= sum_mag;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, win_eff}) begin
            rem_ff <= WW'(rem_shift - {1'b0, win_eff});
            quo_ff <= {quo_ff[UW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[WW-1:0];
            quo_ff <= {quo_ff[UW-2:0], 1'b0};
         end
         step_ff <= step_ff + TW'(1);
      end
      if (cmd.finish) begin
         rsp_ff.average       <= avg;
         rsp_ff.end_of_stream <= last_ff;
      end
   end

   assign status.div_last = (step_ff == TW'(smavg_pkg::DIV_STEPS - 1));
   assign rsp_payload     = rsp_ff;

endmodule

// ===== hdl/simple_moving_average_top.sv =====
// Channel  Direction  Ports                                   Payload
// req      in         req_valid, req_ready, req_payload       sample, last_sample
// rsp      out        rsp_valid, rsp_ready, rsp_payload       average, end_of_stream
// csr      in         csr_valid, csr_ready, csr_data          window_size
//
// A transaction is accepted in the idle state, which also reads the history ring. Then the
// sum is updated, the bit-serial divider runs, and the output register is loaded once it is
// free; requests are taken only in the idle state, so a new one waits until that load.
// Reset is synchronous and active high; the window size returns to 4.
// A waiting result does not block the next request; a stalled result only holds
// the finished quotient until the output register is free.
module simple_moving_average_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  smavg_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output smavg_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smavg_pkg::WIN_W-1:0]       csr_data
);

   smavg_pkg::cmd_type    cmd;
   smavg_pkg::status_type status;

   assign csr_ready = 1'b1;

   smavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smavg_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction was still in progress");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result presented without a transaction in progress");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && rsp_valid) |-> rsp_ready)
      else $error("output register overwritten before it was taken");
`endif

endmodule
